/* hw/rtl/bzss_pkg.sv */
// shared types, constants and helper functions of the bzip2 signature scanner
package bzss_pkg;

  // counter and length widths
  localparam int LEN_W = 32;
  localparam int CNT_W = 16;

  // window geometry
  localparam int WIN_W  = 48;
  localparam int FILL_W = 3;

  // stream magics
  localparam logic [WIN_W-1:0] MAGIC_BLOCK = 48'h3141_5926_5359;
  localparam logic [WIN_W-1:0] MAGIC_END   = 48'h1772_4538_5090;

  // header characters
  localparam logic [7:0] CHAR_B   = 8'h42;
  localparam logic [7:0] CHAR_Z   = 8'h5a;
  localparam logic [7:0] CHAR_H   = 8'h68;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // result item layout
  localparam int OUT_BITS  = 1 + CNT_W + CNT_W + 1 + LEN_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_W      = 8;

  // scan modes
  typedef enum logic [3:0] {
    MODE_HEADER = 4'b0001,
    MODE_MAGIC  = 4'b0010,
    MODE_SEARCH = 4'b0100,
    MODE_DONE   = 4'b1000
  } mode_t;

  // saturating length add of a small amount
  function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] a,
                                              input logic [2:0] n);
    logic [LEN_W:0] sum;
    sum = {1'b0, a} + {{(LEN_W-2){1'b0}}, n};
    return sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
  endfunction

  // saturating counter increment
  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] a);
    return (a == {CNT_W{1'b1}}) ? a : a + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

  // member header test, oldest byte in the top bits
  function automatic logic header_ok(input logic [31:0] w);
    return (w[31:24] == CHAR_B) && (w[23:16] == CHAR_Z) && (w[15:8] == CHAR_H) &&
           (w[7:0] >= CHAR_ONE) && (w[7:0] <= CHAR_NINE);
  endfunction

endpackage

/* hw/rtl/bzip2_signature_scanner_top.sv */
// Latency: the result item is valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; the whole window compare, header test and
// saturating counters settle between the state registers and the result register.
// A byte is refused only while a finished result waits at the output.
// Reset: synchronous active-low rst_n clears the scan state and drops out_tvalid;
// after each result the scan state returns to its reset values.
module bzip2_signature_scanner_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bzss_pkg::IN_W-1:0]    in_tdata,   // data_byte[7:0]
  input  logic                         in_tlast,   // last_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // found[0], members[16:1], blocks[32:17], all_terminated[33], span_length[65:34]
  output logic [bzss_pkg::OUT_W-1:0]   out_tdata
);

  // scan state
  logic [bzss_pkg::WIN_W-1:0]  win_r;
  logic [bzss_pkg::FILL_W-1:0] fill_r;
  bzss_pkg::mode_t             mode_r;
  logic [bzss_pkg::LEN_W-1:0]  bp_r;
  logic [bzss_pkg::LEN_W-1:0]  cur_r;
  logic [bzss_pkg::CNT_W-1:0]  mem_r;
  logic [bzss_pkg::CNT_W-1:0]  blk_r;
  logic                        all_r;

  // state after one byte
  logic [bzss_pkg::WIN_W-1:0]  win_nxt;
  logic [bzss_pkg::FILL_W-1:0] fill_nxt;
  bzss_pkg::mode_t             mode_nxt;
  logic [bzss_pkg::LEN_W-1:0]  bp_nxt;
  logic [bzss_pkg::LEN_W-1:0]  cur_nxt;
  logic [bzss_pkg::CNT_W-1:0]  mem_nxt;
  logic [bzss_pkg::CNT_W-1:0]  blk_nxt;
  logic                        all_nxt;

  // end of data wrap-up
  logic [bzss_pkg::LEN_W-1:0]  cur_fin;
  logic [bzss_pkg::CNT_W-1:0]  mem_fin;
  logic                        all_fin;
  logic [bzss_pkg::LEN_W-1:0]  span;
  logic [31:0]                 tail_hdr;

  // result register
  logic                        out_valid_r;
  logic [bzss_pkg::OUT_W-1:0]  out_data_r;

  logic in_fire;

  assign in_tready  = !(out_valid_r && !out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // per-byte scan step
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    mode_nxt = mode_r;
    bp_nxt   = bzss_pkg::len_add(bp_r, 3'd1);
    cur_nxt  = cur_r;
    mem_nxt  = mem_r;
    blk_nxt  = blk_r;
    all_nxt  = all_r;
    if (mode_r != bzss_pkg::MODE_DONE) begin
      win_nxt  = {win_r[bzss_pkg::WIN_W-9:0], in_tdata};
      fill_nxt = (fill_r == 3'd6) ? 3'd6 : fill_r + 3'd1;
      case (mode_r)
        bzss_pkg::MODE_HEADER: begin
          if (fill_nxt >= 3'd4) begin
            if (bzss_pkg::header_ok(win_nxt[31:0])) begin
              cur_nxt  = bzss_pkg::len_add(cur_r, 3'd4);
              fill_nxt = 3'd0;
              mode_nxt = bzss_pkg::MODE_MAGIC;
            end else begin
              mode_nxt = bzss_pkg::MODE_DONE;
            end
          end
        end
        bzss_pkg::MODE_MAGIC: begin
          if (fill_nxt == 3'd6) begin
            if (win_nxt == bzss_pkg::MAGIC_BLOCK) begin
              blk_nxt  = bzss_pkg::cnt_inc(blk_r);
              cur_nxt  = bzss_pkg::len_add(cur_r, 3'd6);
              fill_nxt = 3'd0;
              mode_nxt = bzss_pkg::MODE_SEARCH;
            end else if (win_nxt == bzss_pkg::MAGIC_END) begin
              // member closed properly
              cur_nxt  = bzss_pkg::len_add(cur_r, 3'd6);
              fill_nxt = 3'd0;
              mem_nxt  = bzss_pkg::cnt_inc(mem_r);
              mode_nxt = bzss_pkg::MODE_HEADER;
            end else begin
              // unterminated member, retest the oldest bytes as a header
              mem_nxt = bzss_pkg::cnt_inc(mem_r);
              all_nxt = 1'b0;
              if (bzss_pkg::header_ok(win_nxt[47:16])) begin
                cur_nxt  = bzss_pkg::len_add(cur_r, 3'd4);
                fill_nxt = 3'd2;
                mode_nxt = bzss_pkg::MODE_MAGIC;
              end else begin
                mode_nxt = bzss_pkg::MODE_DONE;
              end
            end
          end
        end
        bzss_pkg::MODE_SEARCH: begin
          if (fill_nxt == 3'd6) begin
            if (win_nxt == bzss_pkg::MAGIC_BLOCK) begin
              cur_nxt  = bp_nxt;
              blk_nxt  = bzss_pkg::cnt_inc(blk_r);
              fill_nxt = 3'd0;
            end else if (win_nxt == bzss_pkg::MAGIC_END) begin
              cur_nxt  = bp_nxt;
              mem_nxt  = bzss_pkg::cnt_inc(mem_r);
              fill_nxt = 3'd0;
              mode_nxt = bzss_pkg::MODE_HEADER;
            end else begin
              fill_nxt = 3'd5;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // wrap-up after the last byte
  always_comb begin
    cur_fin  = cur_nxt;
    mem_fin  = mem_nxt;
    all_fin  = all_nxt;
    tail_hdr = (fill_nxt == 3'd5) ? win_nxt[39:8] : win_nxt[31:0];
    case (mode_nxt)
      bzss_pkg::MODE_MAGIC: begin
        mem_fin = bzss_pkg::cnt_inc(mem_nxt);
        all_fin = 1'b0;
        // a pending tail of four or five bytes may hold one more header
        if (fill_nxt >= 3'd4 && bzss_pkg::header_ok(tail_hdr)) begin
          cur_fin = bzss_pkg::len_add(cur_nxt, 3'd4);
          mem_fin = bzss_pkg::cnt_inc(bzss_pkg::cnt_inc(mem_nxt));
        end
      end
      bzss_pkg::MODE_SEARCH: begin
        cur_fin = bp_nxt;
        mem_fin = bzss_pkg::cnt_inc(mem_nxt);
        all_fin = 1'b0;
      end
      default: begin
      end
    endcase
    span = (bp_nxt < bzss_pkg::LEN_W'(4)) ? bp_nxt : cur_fin;
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
      mode_r <= bzss_pkg::MODE_HEADER;
      bp_r   <= '0;
      cur_r  <= '0;
      mem_r  <= '0;
      blk_r  <= '0;
      all_r  <= 1'b1;
    end else if (in_fire) begin
      if (in_tlast) begin
        win_r  <= '0;
        fill_r <= '0;
        mode_r <= bzss_pkg::MODE_HEADER;
        bp_r   <= '0;
        cur_r  <= '0;
        mem_r  <= '0;
        blk_r  <= '0;
        all_r  <= 1'b1;
      end else begin
        win_r  <= win_nxt;
        fill_r <= fill_nxt;
        mode_r <= mode_nxt;
        bp_r   <= bp_nxt;
        cur_r  <= cur_nxt;
        mem_r  <= mem_nxt;
        blk_r  <= blk_nxt;
        all_r  <= all_nxt;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_data_r <= {{(bzss_pkg::OUT_W - bzss_pkg::OUT_BITS){1'b0}},
                     span, all_fin, blk_nxt, mem_fin, (mem_fin != '0)};
    end
  end

  // fill never exceeds the window
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 3'd6)
    else $error("window fill out of range");

  // a header is tested as soon as four bytes are pending
  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == bzss_pkg::MODE_HEADER) |-> (fill_r < 3'd4))
    else $error("header pending too long");

  // consumed length never passes received length
  assert property (@(posedge clk) disable iff (!rst_n) cur_r <= bp_r)
    else $error("cursor ahead of byte count");

  // last byte yields a result next cycle, other bytes none
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> out_tvalid)
    else $error("missing result after last byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_tlast) |=> !out_tvalid)
    else $error("result without last byte");

  // found flag agrees with member count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[16:1] != '0)))
    else $error("found flag inconsistent");

endmodule
